// ===== rtl/slt_pkg.sv =====
// shared types and constants for the sorted list table
// no dependencies
package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic                     is_insert;
        logic                     is_delete;
        logic                     is_search;
        logic                     is_dump;
        logic signed [DATA_W-1:0] value;
    } slt_item_t;

endpackage

// ===== rtl/sorted_list_table_unit.sv =====
// sorted list table top level: front queue feeding the cell-row back end
// path: a command beat is queued in the front end, executed from the queue head in the
// cell row and its result registered; a dump of a non-empty table first enters the dump
// state, then sends one result beat per entry and holds the back end until the last one;
// insert, delete and search leave the back end free for the next queued command
// reset: entry count cleared and command queue emptied; entry values undefined
module sorted_list_table_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [slt_pkg::CMD_W-1:0]          cmd,
    input  logic signed [slt_pkg::DATA_W-1:0]  value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [slt_pkg::STATUS_W-1:0]       status,
    output logic signed [slt_pkg::DATA_W-1:0]  value_out,
    output logic [slt_pkg::POS_W-1:0]          position,
    output logic [slt_pkg::COUNT_W-1:0]        count,
    output logic                               last
);
    import slt_pkg::*;

    slt_item_t q_item;
    logic      q_valid;
    logic      q_pop;

    slt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .value     (value),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop)
    );

    slt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .value_out (value_out),
        .position  (position),
        .count     (count),
        .last      (last)
    );

endmodule

// ===== rtl/slt_front.sv =====
// command front end: accepts beats, decodes the command, queues them
// depends on slt_pkg
module slt_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  logic [slt_pkg::CMD_W-1:0]        cmd,
    input  logic signed [slt_pkg::DATA_W-1:0] value,
    output slt_pkg::slt_item_t               q_item,
    output logic                             q_valid,
    input  logic                             q_pop
);
    import slt_pkg::*;

    slt_item_t  fifo_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    slt_item_t  item_in;
    cmd_t       cmd_code;

    assign cmd_stall = (fill_reg == 2'd2);
    assign push      = cmd_valid && !cmd_stall;
    assign q_valid   = (fill_reg != 2'd0);
    assign q_item    = fifo_reg[rd_ptr_reg];
    assign cmd_code  = cmd_t'(cmd);

    always_comb
    begin
        item_in           = '0;
        item_in.value     = value;
        case (cmd_code)
            CMD_INSERT: item_in.is_insert = 1'b1;
            CMD_DELETE: item_in.is_delete = 1'b1;
            CMD_SEARCH: item_in.is_search = 1'b1;
            CMD_DUMP:   item_in.is_dump   = 1'b1;
            default:    item_in.is_dump   = 1'b1;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/slt_back.sv =====
// execution back end: compare-and-shift cell row, dump sequencer, result register
// depends on slt_pkg
module slt_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  slt_pkg::slt_item_t                 q_item,
    input  logic                               q_valid,
    output logic                               q_pop,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [slt_pkg::STATUS_W-1:0]       status,
    output logic signed [slt_pkg::DATA_W-1:0]  value_out,
    output logic [slt_pkg::POS_W-1:0]          position,
    output logic [slt_pkg::COUNT_W-1:0]        count,
    output logic                               last
);
    import slt_pkg::*;

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic signed [DATA_W-1:0]  entry_reg  [CAPACITY];
    logic signed [DATA_W-1:0]  entry_next [CAPACITY];

    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [DATA_W-1:0]  value_out_reg;
    logic signed [DATA_W-1:0]  value_out_next;
    logic [POS_W-1:0]          position_reg;
    logic [POS_W-1:0]          position_next;
    logic [COUNT_W-1:0]        count_out_reg;
    logic [COUNT_W-1:0]        count_out_next;
    logic                      last_reg;
    logic                      last_next;

    logic [CAPACITY-1:0]       cell_vld;
    logic [CAPACITY-1:0]       cell_gt;
    logic [CAPACITY-1:0]       cell_ge;
    logic [CAPACITY-1:0]       cell_eq;
    logic [CAPACITY-1:0]       cell_at_cnt;
    logic [CAPACITY-1:0]       prev_gt;
    logic signed [DATA_W-1:0]  prev_val [CAPACITY];
    logic signed [DATA_W-1:0]  next_val [CAPACITY];

    logic                      out_free;
    logic                      exec;
    logic                      found;
    logic                      is_full;
    logic                      is_empty;
    logic                      do_insert;
    logic                      do_delete;
    logic                      dump_last;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign exec     = (state_reg == S_RUN) && q_valid && out_free;
    assign q_pop    = exec;
    assign found    = |cell_eq;
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign do_insert = exec && q_item.is_insert && !is_full;
    assign do_delete = exec && q_item.is_delete && found;
    assign dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // one compare-and-shift cell per entry
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_vld[i]    = (CNT_W'(i) < count_reg);
        assign cell_gt[i]     = cell_vld[i] && (entry_reg[i] > q_item.value);
        assign cell_ge[i]     = cell_vld[i] && (entry_reg[i] >= q_item.value);
        assign cell_eq[i]     = cell_vld[i] && (entry_reg[i] == q_item.value);
        assign cell_at_cnt[i] = (CNT_W'(i) == count_reg);

        if (i == 0)
        begin : g_first
            assign prev_gt[i]  = 1'b0;
            assign prev_val[i] = entry_reg[i];
        end
        else
        begin : g_mid
            assign prev_gt[i]  = cell_gt[i-1];
            assign prev_val[i] = entry_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_val[i] = entry_reg[i];
        end
        else
        begin : g_body
            assign next_val[i] = entry_reg[i+1];
        end

        always_comb
        begin
            entry_next[i] = entry_reg[i];
            if (do_insert)
            begin
                if ((cell_gt[i] || cell_at_cnt[i]) && !prev_gt[i])
                begin
                    entry_next[i] = q_item.value;
                end
                else if (prev_gt[i])
                begin
                    entry_next[i] = prev_val[i];
                end
            end
            else if (do_delete && cell_ge[i])
            begin
                entry_next[i] = next_val[i];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        position_next  = position_reg;
        count_out_next = count_out_reg;
        last_next      = last_reg;

        case (state_reg)
            S_RUN:
            begin
                if (exec)
                begin
                    value_out_next = q_item.value;
                    position_next  = '0;
                    last_next      = 1'b1;
                    if (q_item.is_insert)
                    begin
                        rsp_valid_next = 1'b1;
                        if (is_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            status_next = STAT_OK;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    else if (q_item.is_delete)
                    begin
                        rsp_valid_next = 1'b1;
                        if (is_empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (found)
                        begin
                            status_next = STAT_OK;
                            count_next  = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                    end
                    else if (q_item.is_search)
                    begin
                        rsp_valid_next = 1'b1;
                        status_next    = found ? STAT_OK : STAT_NOT_FOUND;
                    end
                    else if (is_empty)
                    begin
                        rsp_valid_next = 1'b1;
                        status_next    = STAT_EMPTY;
                        value_out_next = '0;
                    end
                    else
                    begin
                        state_next = S_DUMP;
                        idx_next   = '0;
                    end
                    count_out_next = COUNT_W'(count_next);
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    value_out_next = entry_reg[idx_reg];
                    position_next  = POS_W'(idx_reg);
                    count_out_next = COUNT_W'(count_reg);
                    last_next      = dump_last;
                    if (dump_last)
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            entry_reg[k] <= entry_next[k];
        end
        status_reg    <= status_next;
        value_out_reg <= value_out_next;
        position_reg  <= position_next;
        count_out_reg <= count_out_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign position  = position_reg;
    assign count     = count_out_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/slt_checker.sv =====
// port-level checks for the sorted list table, bound to the top level
// depends on slt_pkg and sorted_list_table_unit
module slt_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rsp_valid,
    input  logic                               rsp_stall,
    input  logic [slt_pkg::STATUS_W-1:0]       status,
    input  logic signed [slt_pkg::DATA_W-1:0]  value_out,
    input  logic [slt_pkg::COUNT_W-1:0]        count,
    input  logic                               last
);
    import slt_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(value_out) && $stable(last))
        else $error("result beat changed while stalled");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count <= COUNT_W'(CAPACITY))
        else $error("count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_FULL) |-> count == COUNT_W'(CAPACITY))
        else $error("full status with room left");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_EMPTY) |-> (count == '0) && last)
        else $error("empty status with entries held");

    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> status == STAT_OK)
        else $error("non-final beat without ok status");

endmodule

bind sorted_list_table_unit slt_checker u_slt_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// testbench for sorted_list_table_unit: directed and random command beats checked
// against a behavioral sorted table predictor; depends on slt_pkg and the rtl top level
module tb;
    import slt_pkg::*;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct {
        status_t                   st;
        logic signed [DATA_W-1:0]  val;
        logic [POS_W-1:0]          pos;
        logic [COUNT_W-1:0]        cnt;
        logic                      lst;
    } result_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cmd_valid;
    logic                        cmd_stall;
    logic [CMD_W-1:0]            cmd;
    logic signed [DATA_W-1:0]    value;
    logic                        rsp_valid;
    logic                        rsp_stall = 1'b0;
    logic [STATUS_W-1:0]         status;
    logic signed [DATA_W-1:0]    value_out;
    logic [POS_W-1:0]            position;
    logic [COUNT_W-1:0]          count;
    logic                        last;

    logic signed [DATA_W-1:0]    held[$];
    result_t                     expected_results[$];
    int                          error_count = 0;
    int                          send_idle_pct = 0;
    int                          rsp_stall_pct = 0;
    int                          hold_off_cycles = 0;

    sorted_list_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .value_out (value_out),
        .position  (position),
        .count     (count),
        .last      (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stall, with a counted hold-off
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            rsp_stall = 1'b1;
            hold_off_cycles--;
        end
        else
            rsp_stall = ($urandom_range(99) < rsp_stall_pct);
    end

    task automatic predict_command(input cmd_t c, input logic signed [DATA_W-1:0] v);
        result_t r;
        int      i;
        int      n;
        n     = held.size();
        r.val = v;
        r.pos = '0;
        r.lst = 1'b1;
        r.st  = STAT_OK;
        case (c)
            CMD_INSERT:
            begin
                if (n >= CAPACITY)
                    r.st = STAT_FULL;
                else
                begin
                    i = 0;
                    while (i < n && held[i] <= v)
                        i++;
                    held.insert(i, v);
                end
            end
            CMD_DELETE:
            begin
                if (n == 0)
                    r.st = STAT_EMPTY;
                else
                begin
                    r.st = STAT_NOT_FOUND;
                    for (i = 0; i < n; i++)
                    begin
                        if (held[i] == v)
                        begin
                            held.delete(i);
                            r.st = STAT_OK;
                            break;
                        end
                    end
                end
            end
            CMD_SEARCH:
            begin
                r.st = STAT_NOT_FOUND;
                for (i = 0; i < n; i++)
                    if (held[i] == v)
                        r.st = STAT_OK;
            end
            default:
            begin
                if (n == 0)
                begin
                    r.st  = STAT_EMPTY;
                    r.val = '0;
                end
            end
        endcase
        r.cnt = COUNT_W'(held.size());
        if (c == CMD_DUMP && n != 0)
        begin
            for (i = 0; i < n; i++)
            begin
                r.val = held[i];
                r.pos = POS_W'(i);
                r.lst = (i == n - 1);
                expected_results.push_back(r);
            end
        end
        else
            expected_results.push_back(r);
    endtask

    task automatic send_cmd(input cmd_t c, input logic signed [DATA_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            cmd       = CMD_W'($urandom_range(3));
            value     = $urandom;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd       = c;
        value     = v;
        do
            @(posedge clk);
        while (cmd_stall);
        predict_command(c, v);
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (held.size() != 0 && sel < 45)
            return held[$urandom_range(held.size() - 1)];
        if (sel < 75)
            return $signed($urandom_range(8)) - 4;
        return $urandom;
    endfunction

    function automatic cmd_t pick_cmd();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return CMD_INSERT;
        if (sel < 65)
            return CMD_DELETE;
        if (sel < 85)
            return CMD_SEARCH;
        return CMD_DUMP;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : rsp_check
        result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat, expected none actual status %0d value %0d",
                         $time, status, value_out);
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("status", int'(want.st), int'(status));
                compare_field("value_out", want.val, value_out);
                compare_field("position", int'(want.pos), int'(position));
                compare_field("count", int'(want.cnt), int'(count));
                compare_field("last", int'(want.lst), int'(last));
            end
        end
    end

    task automatic test_empty_table();
        send_cmd(CMD_SEARCH, 7);
        send_cmd(CMD_DELETE, -7);
        send_cmd(CMD_DUMP, VAL_MAX);
    endtask

    task automatic test_ordering();
        send_cmd(CMD_INSERT, VAL_MAX);
        send_cmd(CMD_INSERT, VAL_MIN);
        send_cmd(CMD_INSERT, 0);
        send_cmd(CMD_INSERT, -1);
        send_cmd(CMD_INSERT, 0);
        send_cmd(CMD_INSERT, 1);
        send_cmd(CMD_DUMP, -1);
        send_cmd(CMD_SEARCH, -1);
        send_cmd(CMD_SEARCH, 2);
        send_cmd(CMD_DELETE, 3);
        send_cmd(CMD_DELETE, 0);
        // tail removal, then inserts at and past the new tail
        send_cmd(CMD_DELETE, VAL_MAX);
        send_cmd(CMD_INSERT, 1);
        send_cmd(CMD_INSERT, 100);
        send_cmd(CMD_DUMP, 0);
        drain_results();
    endtask

    task automatic test_full_table();
        while (held.size() < CAPACITY)
            send_cmd(CMD_INSERT, pick_value());
        send_cmd(CMD_INSERT, pick_value());
        send_cmd(CMD_SEARCH, pick_value());
        send_cmd(CMD_DUMP, $urandom);
        while (held.size() != 0)
            send_cmd(CMD_DELETE, held[$urandom_range(held.size() - 1)]);
        send_cmd(CMD_DELETE, pick_value());
        send_cmd(CMD_DUMP, $urandom);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct   = 0;
        rsp_stall_pct   = 0;
        hold_off_cycles = 400;
        repeat (10)
            send_cmd(CMD_INSERT, pick_value());
        repeat (6)
        begin
            send_cmd(CMD_DUMP, $urandom);
            send_cmd(CMD_SEARCH, pick_value());
        end
        drain_results();
    endtask

    task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (n_items)
            send_cmd(pick_cmd(), pick_value());
        drain_results();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = CMD_INSERT;
        value     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_ordering();
        test_full_table();
        test_output_backpressure();
        run_random_phase(13, 0, 0);
        run_random_phase(13, 48, 0);
        run_random_phase(13, 0, 48);
        run_random_phase(13, 31, 31);

        @(negedge clk);
        cmd_valid = 1'b0;
        repeat (50000)
            if (expected_results.size() != 0)
                @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count += expected_results.size();
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
